// ===== sv/lba_pkg.sv =====
`timescale 1ns / 1ps
package lba_pkg;

   localparam int MAP_W     = 32;
   localparam int KEY_W     = 64;
   localparam int CNT_W     = 6;
   localparam int BLK_W     = 5;
   localparam int BLK_PTR_W = 6;
   localparam int MAX_OUT   = 32;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [BLK_PTR_W-1:0] END_MARK = 6'd63;

   localparam logic REQ_CREATE = 1'b0;
   localparam logic REQ_LIST   = 1'b1;

   localparam logic REG_DISK_SIZE = 1'b0;
   localparam logic REG_PREOCC    = 1'b1;

   typedef enum logic [2:0] {
      ST_CREATED   = 3'd0,
      ST_LISTED    = 3'd1,
      ST_DIR_FULL  = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_BAD_COUNT = 3'd4,
      ST_NO_SPACE  = 3'd5,
      ST_NOT_FOUND = 3'd6
   } lba_status_type;

   typedef struct packed {
      logic              req_type;
      logic [KEY_W-1:0]  file_key;
      logic [CNT_W-1:0]  block_count;
   } lba_req_type;

   typedef struct packed {
      lba_status_type    status;
      logic [BLK_W-1:0]  block_index;
      logic [MAP_W-1:0]  used_map;
      logic              is_last;
   } lba_rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [BLK_W-1:0]  start;
      logic [CNT_W-1:0]  length;
   } lba_dir_entry_type;

   localparam int DIR_ENTRY_W = $bits(lba_dir_entry_type);

   typedef struct packed {
      logic           accept;
      logic           scan;
      logic           blk_clear;
      logic           count_step;
      logic           alloc_step;
      logic           link_end;
      logic           walk_load;
      logic           walk_read;
      logic           walk_adv;
      logic           set_res;
      lba_status_type res_status;
      logic           load_out;
   } lba_cmd_type;

   typedef struct packed {
      logic req_is_list;
      logic dir_full;
      logic scan_hit;
      logic scan_done;
      logic count_zero;
      logic count_ok;
      logic count_end;
      logic alloc_done;
      logic walk_ok;
      logic res_last;
      logic out_free;
   } lba_sts_type;

endpackage

// ===== sv/lba_ram.sv =====
`timescale 1ns / 1ps
module lba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lba_ctrl.sv =====
`timescale 1ns / 1ps
module lba_ctrl import lba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lba_sts_type sts,
   output lba_cmd_type cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SCAN     = 9'b000000010,
      S_COUNT    = 9'b000000100,
      S_ALLOC    = 9'b000001000,
      S_LINK     = 9'b000010000,
      S_WALK     = 9'b000100000,
      S_WALK_NXT = 9'b001000000,
      S_EMIT     = 9'b010000000,
      S_SPARE    = 9'b100000000
   } lba_state_type;

   lba_state_type state_ff;
   lba_state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!sts.req_is_list && sts.dir_full) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_DIR_FULL;
               state_in       = S_EMIT;
            end else if (sts.scan_hit) begin
               if (sts.req_is_list) begin
                  cmd.walk_load = 1'b1;
                  state_in      = S_WALK;
               end else begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_DUPLICATE;
                  state_in       = S_EMIT;
               end
            end else if (sts.scan_done) begin
               if (sts.req_is_list) begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_NOT_FOUND;
                  state_in       = S_EMIT;
               end else if (sts.count_zero) begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_BAD_COUNT;
                  state_in       = S_EMIT;
               end else begin
                  cmd.blk_clear = 1'b1;
                  state_in      = S_COUNT;
               end
            end else begin
               cmd.scan = 1'b1;
            end
         end
         S_COUNT: begin
            if (sts.count_ok) begin
               cmd.blk_clear = 1'b1;
               state_in      = S_ALLOC;
            end else if (sts.count_end) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_NO_SPACE;
               state_in       = S_EMIT;
            end else begin
               cmd.count_step = 1'b1;
            end
         end
         S_ALLOC: begin
            if (sts.alloc_done) begin
               state_in = S_LINK;
            end else begin
               cmd.alloc_step = 1'b1;
            end
         end
         S_LINK: begin
            // terminate the chain and record the file
            cmd.link_end   = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_CREATED;
            state_in       = S_EMIT;
         end
         S_WALK: begin
            if (sts.walk_ok) begin
               cmd.walk_read = 1'b1;
               state_in      = S_WALK_NXT;
            end else begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
               state_in       = S_EMIT;
            end
         end
         S_WALK_NXT: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_LISTED;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               if (sts.res_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.walk_adv = 1'b1;
                  state_in     = S_WALK;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/lba_datapath.sv =====
`timescale 1ns / 1ps
module lba_datapath import lba_pkg::*; #(
   parameter int DISK_BLOCKS = 32,
   parameter int DIR_ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  lba_cmd_type       cmd,
   output lba_sts_type       sts,
   input  lba_req_type       req_payload,
   input  logic [CNT_W-1:0]  disk_size,
   input  logic [MAP_W-1:0]  preocc_map,
   output logic              rsp_valid,
   output lba_rsp_type       rsp_payload,
   input  logic              rsp_stall
);

   localparam int NB_AW  = $clog2(DISK_BLOCKS);
   localparam int DIR_AW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
   localparam int DIR_CW = $clog2(DIR_ENTRIES + 1);
   localparam int LIM    = (DISK_BLOCKS < MAP_W) ? DISK_BLOCKS : MAP_W;

   lba_req_type                 req_ff, req_in;
   logic [DIR_CW-1:0]           scan_ff, scan_in;
   logic                        pend_ff, pend_in;
   logic [DIR_CW-1:0]           dir_used_ff, dir_used_in;
   logic [CNT_W-1:0]            blk_ff, blk_in;
   logic [CNT_W-1:0]            free_ff, free_in;
   logic [CNT_W-1:0]            taken_ff, taken_in;
   logic [BLK_PTR_W-1:0]        prev_ff, prev_in;
   logic [BLK_W-1:0]            first_ff, first_in;
   logic [MAP_W-1:0]            alloc_ff, alloc_in;
   logic [DISK_BLOCKS-1:0]      nb_valid_ff, nb_valid_in;
   logic                        nbv_rd_ff;
   logic [BLK_PTR_W-1:0]        idx_ff, idx_in;
   logic [BLK_PTR_W-1:0]        nxt_ff, nxt_in;
   logic [CNT_W-1:0]            k_ff, k_in;
   logic [CNT_W-1:0]            len_ff, len_in;
   lba_status_type              res_status_ff, res_status_in;
   logic [BLK_W-1:0]            res_block_ff, res_block_in;
   logic                        res_last_ff, res_last_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   lba_rsp_type                 rsp_ff, rsp_in;

   logic [CNT_W-1:0]            n_blocks;
   logic [MAP_W-1:0]            size_mask;
   logic [MAP_W-1:0]            used_map;
   logic                        free_here;
   logic                        scan_issue;
   logic                        nb_we;
   logic [BLK_PTR_W-1:0]        nb_wdata;
   logic [BLK_PTR_W-1:0]        nb_rdata;
   logic [BLK_PTR_W-1:0]        nxt;
   logic                        next_ok;
   logic [DIR_ENTRY_W-1:0]      dir_rdata;
   lba_dir_entry_type           dir_rd;
   lba_dir_entry_type           dir_wr;

   function automatic logic walk_cond(input logic [BLK_PTR_W-1:0] idx,
                                      input logic [CNT_W-1:0] k,
                                      input logic [CNT_W-1:0] len);
      return (k < CNT_W'(MAX_OUT)) && (k < len) && (idx != END_MARK) &&
             ({1'b0, idx} < (BLK_PTR_W+1)'(DISK_BLOCKS));
   endfunction

   lba_ram #(
      .WIDTH (BLK_PTR_W),
      .DEPTH (DISK_BLOCKS)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (nb_we),
      .wr_addr (prev_ff[NB_AW-1:0]),
      .wr_data (nb_wdata),
      .rd_addr (idx_ff[NB_AW-1:0]),
      .rd_data (nb_rdata)
   );

   lba_ram #(
      .WIDTH (DIR_ENTRY_W),
      .DEPTH (DIR_ENTRIES)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (cmd.link_end),
      .wr_addr (dir_used_ff[DIR_AW-1:0]),
      .wr_data (dir_wr),
      .rd_addr (scan_ff[DIR_AW-1:0]),
      .rd_data (dir_rdata)
   );

   assign dir_rd = lba_dir_entry_type'(dir_rdata);

   always_comb begin
      dir_wr        = '0;
      dir_wr.key    = req_ff.file_key;
      dir_wr.start  = first_ff;
      dir_wr.length = req_ff.block_count;
   end

   // occupancy, limited to the blocks in use
   always_comb begin
      n_blocks = (disk_size > CNT_W'(LIM)) ? CNT_W'(LIM) : disk_size;
      for (int b = 0; b < MAP_W; b++) begin
         size_mask[b] = (CNT_W'(b) < n_blocks);
      end
      used_map  = (preocc_map | alloc_ff) & size_mask;
      free_here = (blk_ff < n_blocks) && !used_map[blk_ff[BLK_W-1:0]];
   end

   assign scan_issue = cmd.scan && (scan_ff < dir_used_ff);
   assign nxt        = nbv_rd_ff ? nb_rdata : END_MARK;
   assign next_ok    = walk_cond(nxt, k_ff + CNT_W'(1), len_ff);
   assign nb_we      = (cmd.alloc_step && free_here && (taken_ff != '0)) || cmd.link_end;
   assign nb_wdata   = cmd.link_end ? END_MARK : blk_ff;

   always_comb begin
      sts             = '0;
      sts.req_is_list = (req_ff.req_type == REQ_LIST);
      sts.dir_full    = (dir_used_ff == DIR_CW'(DIR_ENTRIES));
      sts.scan_hit    = pend_ff && (dir_rd.key == req_ff.file_key);
      sts.scan_done   = !pend_ff && (scan_ff == dir_used_ff);
      sts.count_zero  = (req_ff.block_count == '0);
      sts.count_ok    = (free_ff >= req_ff.block_count);
      sts.count_end   = (blk_ff >= n_blocks);
      sts.alloc_done  = (taken_ff == req_ff.block_count);
      sts.walk_ok     = walk_cond(idx_ff, k_ff, len_ff);
      sts.res_last    = res_last_ff;
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      req_in        = cmd.accept ? req_payload : req_ff;
      scan_in       = scan_ff;
      pend_in       = scan_issue;
      dir_used_in   = dir_used_ff;
      blk_in        = blk_ff;
      free_in       = free_ff;
      taken_in      = taken_ff;
      prev_in       = prev_ff;
      first_in      = first_ff;
      alloc_in      = alloc_ff;
      nb_valid_in   = nb_valid_ff;
      idx_in        = idx_ff;
      nxt_in        = nxt_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      res_last_in   = res_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      if (cmd.accept) begin
         scan_in = '0;
      end else if (scan_issue) begin
         scan_in = scan_ff + DIR_CW'(1);
      end

      if (cmd.blk_clear) begin
         blk_in   = '0;
         free_in  = '0;
         taken_in = '0;
      end

      if (cmd.count_step) begin
         blk_in = blk_ff + CNT_W'(1);
         if (free_here) begin
            free_in = free_ff + CNT_W'(1);
         end
      end

      if (cmd.alloc_step) begin
         blk_in = blk_ff + CNT_W'(1);
         if (free_here) begin
            alloc_in[blk_ff[BLK_W-1:0]] = 1'b1;
            taken_in = taken_ff + CNT_W'(1);
            prev_in  = blk_ff;
            if (taken_ff == '0) begin
               first_in = blk_ff[BLK_W-1:0];
            end
         end
      end

      if (nb_we) begin
         nb_valid_in[prev_ff[NB_AW-1:0]] = 1'b1;
      end

      if (cmd.link_end) begin
         dir_used_in = dir_used_ff + DIR_CW'(1);
      end

      if (cmd.walk_load) begin
         idx_in = {1'b0, dir_rd.start};
         len_in = dir_rd.length;
         k_in   = '0;
      end else if (cmd.walk_adv) begin
         idx_in = nxt_ff;
         k_in   = k_ff + CNT_W'(1);
      end

      if (cmd.set_res) begin
         res_status_in = cmd.res_status;
         nxt_in        = nxt;
         case (cmd.res_status)
            ST_CREATED: begin
               res_block_in = first_ff;
               res_last_in  = 1'b1;
            end
            ST_LISTED: begin
               res_block_in = idx_ff[BLK_W-1:0];
               res_last_in  = !next_ok;
            end
            default: begin
               res_block_in = '0;
               res_last_in  = 1'b1;
            end
         endcase
      end

      if (cmd.load_out) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = res_status_ff;
         rsp_in.block_index = res_block_ff;
         rsp_in.used_map    = used_map;
         rsp_in.is_last     = res_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         dir_used_ff  <= '0;
         alloc_ff     <= '0;
         nb_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         dir_used_ff  <= dir_used_in;
         alloc_ff     <= alloc_in;
         nb_valid_ff  <= nb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      scan_ff       <= scan_in;
      blk_ff        <= blk_in;
      free_ff       <= free_in;
      taken_ff      <= taken_in;
      prev_ff       <= prev_in;
      first_ff      <= first_in;
      nbv_rd_ff     <= nb_valid_ff[idx_ff[NB_AW-1:0]];
      idx_ff        <= idx_in;
      nxt_ff        <= nxt_in;
      k_ff          <= k_in;
      len_ff        <= len_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      res_last_ff   <= res_last_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_alloc_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((alloc_ff & $past(alloc_ff)) == $past(alloc_ff)))
      else $error("allocated block released");

   a_dir_bound: assert property (@(posedge clock) disable iff (reset)
      dir_used_ff <= DIR_CW'(DIR_ENTRIES))
      else $error("directory count beyond capacity");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

   a_created_allocated: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && (res_status_ff == ST_CREATED)) |=> alloc_ff[rsp_ff.block_index])
      else $error("start block of new file not allocated");

endmodule

// ===== sv/linked_block_allocator_core.sv =====
// Linked block allocator. A create request (req_type 0) checks in turn for a full
// directory, a duplicate key, a zero count and too little free space, then takes
// the lowest free blocks, chains them and answers with the start block; a list
// request (req_type 1) returns one result per block of the file's chain, is_last
// on the final one. One request is handled at a time. A create searches the
// directory entry by entry, then counts the free blocks one block at a time and then
// allocates one block at a time. A list searches the directory, then for each block
// listed reads the next-block memory before giving the result. A new request
// is taken while the final result still waits in the output register.
// Configuration (disk_size at 0x0, preoccupied_map at 0x4) is to be written only
// while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
module linked_block_allocator_core import lba_pkg::*; #(
   parameter int DISK_BLOCKS = 32,
   parameter int DIR_ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lba_req_type       req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lba_rsp_type       rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [CNT_W-1:0] disk_size_ff, disk_size_in;
   logic [MAP_W-1:0] preocc_ff, preocc_in;
   logic             csr_wr;
   lba_cmd_type      cmd;
   lba_sts_type      sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      disk_size_in = disk_size_ff;
      preocc_in    = preocc_ff;
      csr_prdata   = '0;
      case (csr_paddr[2])
         REG_DISK_SIZE: begin
            csr_prdata = {{(CSR_DW-CNT_W){1'b0}}, disk_size_ff};
            if (csr_wr) begin
               disk_size_in = csr_pwdata[CNT_W-1:0];
            end
         end
         REG_PREOCC: begin
            csr_prdata = preocc_ff;
            if (csr_wr) begin
               preocc_in = csr_pwdata[MAP_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_size_ff <= CNT_W'(32);
         preocc_ff    <= '0;
      end else begin
         disk_size_ff <= disk_size_in;
         preocc_ff    <= preocc_in;
      end
   end

   lba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lba_datapath #(
      .DISK_BLOCKS (DISK_BLOCKS),
      .DIR_ENTRIES (DIR_ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .disk_size   (disk_size_ff),
      .preocc_map  (preocc_ff),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import lba_pkg::*;

   localparam int DISK_N       = 32;
   localparam int DIR_N        = 16;
   localparam int RANDOM_ITEMS = 480;
   localparam int KEY_POOL_N   = 24;
   localparam int CYCLE_LIMIT  = 2_000_000;

   localparam logic [CSR_AW-1:0] DISK_SIZE_ADDR = {REG_DISK_SIZE, 2'b00};
   localparam logic [CSR_AW-1:0] PREOCC_ADDR    = {REG_PREOCC, 2'b00};
   localparam logic [KEY_W-1:0]  KEY_ONES       = '1;

   typedef struct {
      bit                to_csr;
      logic [CSR_AW-1:0] addr;
      logic [CSR_DW-1:0] data;
      lba_req_type       req;
      bit                typed;
      lba_rsp_type       want;
   } plan_step_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   lba_req_type       req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   lba_rsp_type       rsp_payload;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // shadow of the allocator
   logic [CNT_W-1:0]     disk_size_q = 6'd32;
   logic [MAP_W-1:0]     preocc_q = '0;
   logic [MAP_W-1:0]     alloc_q = '0;
   logic [BLK_PTR_W-1:0] link_tbl [DISK_N];
   logic [KEY_W-1:0]     dir_key_q [DIR_N];
   logic [BLK_W-1:0]     dir_start_q [DIR_N];
   logic [CNT_W-1:0]     dir_len_q [DIR_N];
   int                   dir_count = 0;

   lba_rsp_type      awaited_rsp [$];
   lba_rsp_type      front_rsp;
   logic [KEY_W-1:0] key_pool [KEY_POOL_N];
   plan_step_type    plan [$];

   int        mismatch_count = 0;
   int        rsp_count = 0;
   int        request_count = 0;
   int        setting_count = 0;
   int        status_seen [8];
   int        cycle_count = 0;
   int        burst_left = 0;
   logic [22:0] stall_bits = '0;
   int        stall_phase = 0;
   bit        stall_quiet = 1'b1;

   linked_block_allocator_core #(
      .DISK_BLOCKS(DISK_N),
      .DIR_ENTRIES(DIR_N)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int span_blocks();
      int n;
      n = int'(disk_size_q);
      if (n > DISK_N) n = DISK_N;
      return n;
   endfunction

   function automatic logic [MAP_W-1:0] occupancy();
      int n;
      logic [MAP_W-1:0] m;
      n = span_blocks();
      m = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
      return (preocc_q | alloc_q) & m;
   endfunction

   function automatic int find_entry(logic [KEY_W-1:0] k);
      for (int i = 0; i < dir_count; i++)
         if (dir_key_q[i] == k) return i;
      return -1;
   endfunction

   task automatic queue_rsp(lba_status_type st, int blk, bit last);
      lba_rsp_type r;
      r.status      = st;
      r.block_index = blk[BLK_W-1:0];
      r.used_map    = occupancy();
      r.is_last     = last;
      awaited_rsp.push_back(r);
   endtask

   task automatic allocate_or_walk(lba_req_type r);
      int n, free_n, taken, prev, first, slot, idx, walked;
      logic [MAP_W-1:0] used;
      if (r.req_type == REQ_CREATE) begin
         n = span_blocks();
         used = occupancy();
         free_n = 0;
         if (dir_count >= DIR_N) queue_rsp(ST_DIR_FULL, 0, 1'b1);
         else if (find_entry(r.file_key) >= 0) queue_rsp(ST_DUPLICATE, 0, 1'b1);
         else if (r.block_count == 0) queue_rsp(ST_BAD_COUNT, 0, 1'b1);
         else begin
            for (int i = 0; i < n; i++)
               if (!used[i]) free_n++;
            if (free_n < r.block_count) queue_rsp(ST_NO_SPACE, 0, 1'b1);
            else begin
               taken = 0;
               prev = 0;
               first = 0;
               // take the lowest free blocks and chain them in order
               for (int i = 0; i < n && taken < r.block_count; i++) begin
                  if (!used[i]) begin
                     alloc_q[i] = 1'b1;
                     if (taken == 0) first = i;
                     else link_tbl[prev] = i[BLK_PTR_W-1:0];
                     prev = i;
                     taken++;
                  end
               end
               link_tbl[prev] = END_MARK;
               dir_key_q[dir_count] = r.file_key;
               dir_start_q[dir_count] = first[BLK_W-1:0];
               dir_len_q[dir_count] = r.block_count;
               dir_count++;
               queue_rsp(ST_CREATED, first, 1'b1);
            end
         end
      end else begin
         slot = find_entry(r.file_key);
         walked = 0;
         if (slot >= 0) begin
            idx = int'(dir_start_q[slot]);
            while (walked < MAX_OUT && walked < dir_len_q[slot] && idx != END_MARK &&
                   idx < DISK_N) begin
               queue_rsp(ST_LISTED, idx, 1'b0);
               idx = int'(link_tbl[idx]);
               walked++;
            end
         end
         if (walked == 0) queue_rsp(ST_NOT_FOUND, 0, 1'b1);
         else awaited_rsp[$].is_last = 1'b1;
      end
   endtask

   task automatic push_request(lba_req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 14);
         // lower valid only when a real gap follows
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      request_count++;
      allocate_or_walk(r);
   endtask

   task automatic write_register(logic [CSR_AW-1:0] a, logic [CSR_DW-1:0] d);
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= a;
      csr_pwdata <= d;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      setting_count++;
      if (a == DISK_SIZE_ADDR) disk_size_q = d[CNT_W-1:0];
      else if (a == PREOCC_ADDR) preocc_q = d;
   endtask

   function automatic plan_step_type request_row(logic kind, logic [KEY_W-1:0] k,
                                                 logic [CNT_W-1:0] c);
      plan_step_type s;
      s.to_csr = 1'b0;
      s.addr = '0;
      s.data = '0;
      s.req.req_type = kind;
      s.req.file_key = k;
      s.req.block_count = c;
      s.typed = 1'b0;
      s.want = '0;
      return s;
   endfunction

   function automatic plan_step_type checked_row(logic kind, logic [KEY_W-1:0] k,
                                                 logic [CNT_W-1:0] c, lba_status_type st,
                                                 logic [BLK_W-1:0] b, logic [MAP_W-1:0] m);
      plan_step_type s;
      s = request_row(kind, k, c);
      s.typed = 1'b1;
      s.want.status = st;
      s.want.block_index = b;
      s.want.used_map = m;
      s.want.is_last = 1'b1;
      return s;
   endfunction

   function automatic plan_step_type csr_row(logic [CSR_AW-1:0] a, logic [CSR_DW-1:0] d);
      plan_step_type s;
      s = request_row(REQ_CREATE, '0, '0);
      s.to_csr = 1'b1;
      s.addr = a;
      s.data = d;
      return s;
   endfunction

   // result side: check against the oldest expectation, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (!$isunknown(rsp_payload.status)) status_seen[rsp_payload.status]++;
         if (awaited_rsp.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with nothing awaited: expected none, actual %p",
                     $time, rsp_payload);
         end else begin
            front_rsp = awaited_rsp.pop_front();
            if (rsp_payload.status !== front_rsp.status) begin
               mismatch_count++;
               $display("%0t: status expected %0d actual %0d", $time,
                        front_rsp.status, rsp_payload.status);
            end
            if (rsp_payload.block_index !== front_rsp.block_index) begin
               mismatch_count++;
               $display("%0t: block_index expected %0d actual %0d", $time,
                        front_rsp.block_index, rsp_payload.block_index);
            end
            if (rsp_payload.used_map !== front_rsp.used_map) begin
               mismatch_count++;
               $display("%0t: used_map expected %h actual %h", $time,
                        front_rsp.used_map, rsp_payload.used_map);
            end
            if (rsp_payload.is_last !== front_rsp.is_last) begin
               mismatch_count++;
               $display("%0t: is_last expected %0b actual %0b", $time,
                        front_rsp.is_last, rsp_payload.is_last);
            end
         end
      end
      if (stall_phase == 0 && $urandom_range(0, 7) == 0) begin
         stall_bits = 23'($urandom & $urandom);
         stall_quiet = ($urandom_range(0, 3) == 0);
      end
      rsp_stall <= !stall_quiet && stall_bits[stall_phase];
      stall_phase = (stall_phase == 22) ? 0 : stall_phase + 1;
   end

   initial begin
      lba_req_type item;
      int          sent;
      int          phase_len;
      int          pick;
      logic [CSR_DW-1:0] size_val;
      logic [CSR_DW-1:0] map_val;

      for (int i = 0; i < DISK_N; i++) link_tbl[i] = END_MARK;
      key_pool[0] = '0;
      key_pool[1] = KEY_ONES;
      for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};

      // after reset, then the key and count extremes
      plan.push_back(checked_row(REQ_LIST, '0, 6'd0, ST_NOT_FOUND, 5'd0, 32'h0));
      plan.push_back(checked_row(REQ_CREATE, '0, 6'd0, ST_BAD_COUNT, 5'd0, 32'h0));
      plan.push_back(checked_row(REQ_CREATE, '0, 6'd63, ST_NO_SPACE, 5'd0, 32'h0));
      plan.push_back(checked_row(REQ_CREATE, '0, 6'd1, ST_CREATED, 5'd0, 32'h1));
      plan.push_back(checked_row(REQ_CREATE, '0, 6'd1, ST_DUPLICATE, 5'd0, 32'h1));
      plan.push_back(checked_row(REQ_CREATE, KEY_ONES, 6'd3, ST_CREATED, 5'd1, 32'hF));
      plan.push_back(request_row(REQ_LIST, '0, 6'd0));
      plan.push_back(request_row(REQ_LIST, KEY_ONES, 6'd63));
      plan.push_back(checked_row(REQ_CREATE, key_pool[2], 6'd32, ST_NO_SPACE, 5'd0, 32'hF));
      // no blocks in use: creates fail, chains still list in full
      plan.push_back(csr_row(DISK_SIZE_ADDR, 32'd0));
      plan.push_back(checked_row(REQ_CREATE, key_pool[2], 6'd1, ST_NO_SPACE, 5'd0, 32'h0));
      plan.push_back(request_row(REQ_LIST, KEY_ONES, 6'd0));
      plan.push_back(csr_row(DISK_SIZE_ADDR, 32'd63));
      plan.push_back(request_row(REQ_CREATE, key_pool[2], 6'd2));
      plan.push_back(csr_row(PREOCC_ADDR, 32'hFFFF_FFFF));
      plan.push_back(checked_row(REQ_CREATE, key_pool[3], 6'd1, ST_NO_SPACE, 5'd0,
                                 32'hFFFF_FFFF));
      plan.push_back(request_row(REQ_LIST, key_pool[2], 6'd0));
      // holes in the free map give a chain with gaps
      plan.push_back(csr_row(PREOCC_ADDR, 32'h0000_0140));
      plan.push_back(request_row(REQ_CREATE, key_pool[3], 6'd3));
      plan.push_back(request_row(REQ_LIST, key_pool[3], 6'd0));
      plan.push_back(csr_row(DISK_SIZE_ADDR, 32'd1));
      plan.push_back(request_row(REQ_LIST, key_pool[3], 6'd0));
      plan.push_back(checked_row(REQ_CREATE, key_pool[4], 6'd1, ST_NO_SPACE, 5'd0, 32'h1));
      plan.push_back(csr_row(DISK_SIZE_ADDR, 32'd32));
      plan.push_back(csr_row(PREOCC_ADDR, 32'h0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].to_csr) write_register(plan[i].addr, plan[i].data);
         else begin
            push_request(plan[i].req);
            if (plan[i].typed) begin
               void'(awaited_rsp.pop_back());
               awaited_rsp.push_back(plan[i].want);
            end
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) size_val = 32'd32;
         else if (pick <= 7) size_val = $urandom_range(1, 31);
         else if (pick == 8) size_val = $urandom_range(33, 63);
         else size_val = 32'd0;
         pick = $urandom_range(0, 9);
         if (pick <= 3) map_val = '0;
         else if (pick <= 7) map_val = $urandom & $urandom & $urandom;
         else if (pick == 8) map_val = $urandom & $urandom;
         else map_val = $urandom;
         write_register(DISK_SIZE_ADDR, size_val);
         write_register(PREOCC_ADDR, map_val);

         phase_len = $urandom_range(30, 60);
         repeat (phase_len) begin
            if ($urandom_range(0, 99) < 70) begin
               item.req_type = REQ_LIST;
               // mostly keys that exist, so that chains get walked
               if (dir_count > 0 && $urandom_range(0, 4) != 0)
                  item.file_key = dir_key_q[$urandom_range(0, dir_count - 1)];
               else item.file_key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
               item.block_count = CNT_W'($urandom_range(0, 63));
            end else begin
               item.req_type = REQ_CREATE;
               if ($urandom_range(0, 9) == 0) item.file_key = {$urandom, $urandom};
               else item.file_key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
               pick = $urandom_range(0, 99);
               if (pick < 70) item.block_count = CNT_W'($urandom_range(1, 4));
               else if (pick < 85) item.block_count = CNT_W'($urandom_range(5, 12));
               else if (pick < 95) item.block_count = CNT_W'($urandom_range(0, 63));
               else item.block_count = '0;
            end
            push_request(item);
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("%0d requests under %0d register writes, %0d results checked",
               request_count, setting_count, rsp_count);
      $write("created %0d listed %0d dir-full %0d duplicate %0d bad-count %0d ",
             status_seen[ST_CREATED], status_seen[ST_LISTED],
             status_seen[ST_DIR_FULL], status_seen[ST_DUPLICATE],
             status_seen[ST_BAD_COUNT]);
      $display("no-space %0d not-found %0d", status_seen[ST_NO_SPACE],
               status_seen[ST_NOT_FOUND]);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
